// ===== rtl/core/rc4_pkg.sv =====
package rc4_pkg;

    localparam int RC4_KEY_DEPTH = 256;
    localparam int RC4_PERM_SIZE = 256;
    localparam int RC4_LEN_W     = 9;

    localparam logic [1:0] OP_LOAD_KEY = 2'd0;
    localparam logic [1:0] OP_SCHEDULE = 2'd1;
    localparam logic [1:0] OP_CRYPT    = 2'd2;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] key_index;
        logic [7:0] value;
    } t_rc4_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       schedule_done;
    } t_rc4_out;

    typedef struct packed {
        logic       re;
        logic [7:0] raddr;
        logic       we;
        logic [7:0] waddr;
        logic [7:0] wdata;
    } t_rc4_sbox_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_KSA0,
        ST_KSA1,
        ST_KSA2,
        ST_DATA1,
        ST_DATA2
    } t_rc4_state;

endpackage

// ===== rtl/core/rc4_stream_cipher.sv =====
// RC4 stream cipher.
// Request channel: i_valid / o_stall with i_data {op, key_index, value}.
//   op load key writes one key byte (no result).
//   op schedule fills the permutation with identity, then runs the 256-step
//   key schedule through states KSA0, KSA1 and KSA2 for each step, and
//   clears i and j; the acknowledgement (out_byte 0, schedule_done 1) then
//   lands in the output register.
//   op crypt returns value XOR keystream; a new data request is taken only
//   once the last one is through, as the three permutation reads (S[i], S[j],
//   S[t]) follow one another.
//   Data requests before the first schedule, and op 3, are dropped.
// Result channel: o_valid / i_stall with o_data {out_byte, schedule_done},
//   from an output register; while the receiver stalls, one more result may
//   be finished internally, then o_stall rises.
// Config channel: i_cfg_valid / o_cfg_ready carry key_length; write it only
//   while the block is idle. Zero acts as 1, values above the key depth saturate.
// Reset (synchronous, active low) clears indices, result state and the
//   scheduled flag; key_length returns to 1. Key store and permutation keep
//   no reset value.
module rc4_stream_cipher
    import rc4_pkg::*;
#(
    parameter int KEY_DEPTH = RC4_KEY_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  t_rc4_in              i_data,
    output logic                 o_stall,
    output logic                 o_valid,
    output t_rc4_out             o_data,
    input  logic                 i_stall,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [RC4_LEN_W-1:0] i_cfg_data
);

    localparam int KW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;

    logic [RC4_LEN_W-1:0] r_key_length;
    logic                 r_out_valid;
    t_rc4_out             r_out_data;

    logic          slot_free;
    logic          res_valid;
    t_rc4_out      res;
    logic          key_we;
    logic [KW-1:0] key_waddr;
    logic [7:0]    key_wdata;
    logic          key_re;
    logic [KW-1:0] key_raddr;
    logic [7:0]    key_rdata;
    t_rc4_sbox_req sbox_req;
    logic [7:0]    sbox_rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_length <= RC4_LEN_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_key_length <= i_cfg_data;
        end
    end

    assign slot_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out_data <= res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    rc4_engine #(
        .KEY_DEPTH (KEY_DEPTH),
        .KW        (KW)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_data       (i_data),
        .o_stall      (o_stall),
        .i_slot_free  (slot_free),
        .o_res_valid  (res_valid),
        .o_res        (res),
        .i_key_length (r_key_length),
        .o_key_we     (key_we),
        .o_key_waddr  (key_waddr),
        .o_key_wdata  (key_wdata),
        .o_key_re     (key_re),
        .o_key_raddr  (key_raddr),
        .i_key_rdata  (key_rdata),
        .o_sbox_req   (sbox_req),
        .i_sbox_rdata (sbox_rdata)
    );

    rc4_key_mem #(
        .KEY_DEPTH (KEY_DEPTH),
        .KW        (KW)
    ) u_key_mem (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (key_waddr),
        .i_wdata (key_wdata),
        .i_re    (key_re),
        .i_raddr (key_raddr),
        .o_rdata (key_rdata)
    );

    rc4_sbox_mem u_sbox_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (sbox_req),
        .o_rdata (sbox_rdata)
    );

endmodule

// ===== rtl/core/rc4_key_mem.sv =====
module rc4_key_mem
    import rc4_pkg::*;
#(
    parameter int KEY_DEPTH = RC4_KEY_DEPTH,
    parameter int KW        = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [KW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [KW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] mem [KEY_DEPTH];
    logic [7:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

// ===== rtl/core/rc4_sbox_mem.sv =====
module rc4_sbox_mem
    import rc4_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_rc4_sbox_req i_req,
    output logic [7:0]    o_rdata
);

    logic [7:0] mem [RC4_PERM_SIZE];
    logic [7:0] r_q;
    logic [7:0] r_fwd;
    logic       r_hit;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_q   <= mem[i_req.raddr];
            r_fwd <= i_req.wdata;
        end
    end

    // a read that meets a write to the same entry returns the new data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (i_req.re) begin
            r_hit <= i_req.we && (i_req.waddr == i_req.raddr);
        end
    end

    assign o_rdata = r_hit ? r_fwd : r_q;

endmodule

// ===== rtl/core/rc4_engine.sv =====
module rc4_engine
    import rc4_pkg::*;
#(
    parameter int KEY_DEPTH = RC4_KEY_DEPTH,
    parameter int KW        = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  t_rc4_in              i_data,
    output logic                 o_stall,
    input  logic                 i_slot_free,
    output logic                 o_res_valid,
    output t_rc4_out             o_res,
    input  logic [RC4_LEN_W-1:0] i_key_length,
    output logic                 o_key_we,
    output logic [KW-1:0]        o_key_waddr,
    output logic [7:0]           o_key_wdata,
    output logic                 o_key_re,
    output logic [KW-1:0]        o_key_raddr,
    input  logic [7:0]           i_key_rdata,
    output t_rc4_sbox_req        o_sbox_req,
    input  logic [7:0]           i_sbox_rdata
);

    localparam logic [RC4_LEN_W-1:0] DEPTH_LEN = RC4_LEN_W'(KEY_DEPTH);
    localparam logic [7:0]           LAST_IDX  = 8'(RC4_PERM_SIZE - 1);

    t_rc4_state r_state, n_state;
    logic [7:0]    r_a, n_a;
    logic [7:0]    r_i, n_i;
    logic [7:0]    r_j, n_j;
    logic [7:0]    r_sa, n_sa;
    logic [7:0]    r_t, n_t;
    logic [7:0]    r_val, n_val;
    logic [KW-1:0] r_kpos, n_kpos;
    logic          r_wb_pend, n_wb_pend;
    logic [7:0]    r_wb_addr, n_wb_addr;
    logic [7:0]    r_wb_data, n_wb_data;
    logic          r_res_pend, n_res_pend;
    logic          r_res_sched, n_res_sched;
    logic          r_scheduled, n_scheduled;

    logic                 accept;
    logic [RC4_LEN_W-1:0] eff_len;
    logic [RC4_LEN_W-1:0] kpos_inc;
    logic [7:0]           ks;

    assign o_stall = (r_state != ST_IDLE) || (r_res_pend && !i_slot_free);
    assign accept  = i_valid && !o_stall;

    always_comb begin
        if (i_key_length == '0) begin
            eff_len = RC4_LEN_W'(1);
        end else if (i_key_length > DEPTH_LEN) begin
            eff_len = DEPTH_LEN;
        end else begin
            eff_len = i_key_length;
        end
    end

    assign kpos_inc = RC4_LEN_W'(r_kpos) + RC4_LEN_W'(1);

    // S[j] write-back is still queued, so pick its value when t lands on j
    assign ks = (r_t == r_j) ? r_sa : i_sbox_rdata;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && i_data.op == OP_SCHEDULE) begin
                    n_state = ST_INIT;
                end else if (accept && i_data.op == OP_CRYPT && r_scheduled) begin
                    n_state = ST_DATA1;
                end
            end
            ST_INIT: begin
                if (r_a == LAST_IDX) begin
                    n_state = ST_KSA0;
                end
            end
            ST_KSA0:  n_state = ST_KSA1;
            ST_KSA1:  n_state = ST_KSA2;
            ST_KSA2:  n_state = (r_a == LAST_IDX) ? ST_IDLE : ST_KSA0;
            ST_DATA1: n_state = ST_DATA2;
            ST_DATA2: n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_a         = r_a;
        n_i         = r_i;
        n_j         = r_j;
        n_sa        = r_sa;
        n_t         = r_t;
        n_val       = r_val;
        n_kpos      = r_kpos;
        n_wb_pend   = r_wb_pend;
        n_wb_addr   = r_wb_addr;
        n_wb_data   = r_wb_data;
        n_res_pend  = r_res_pend;
        n_res_sched = r_res_sched;
        n_scheduled = r_scheduled;
        o_key_we    = 1'b0;
        o_key_waddr = i_data.key_index[KW-1:0];
        o_key_wdata = i_data.value;
        o_key_re    = 1'b0;
        o_key_raddr = r_kpos;
        o_sbox_req  = '0;
        o_res_valid = 1'b0;
        o_res.out_byte      = r_res_sched ? 8'h00 : (r_val ^ ks);
        o_res.schedule_done = r_res_sched;

        unique case (r_state)
            ST_IDLE: begin
                if (r_wb_pend) begin
                    o_sbox_req.we    = 1'b1;
                    o_sbox_req.waddr = r_wb_addr;
                    o_sbox_req.wdata = r_wb_data;
                    n_wb_pend        = 1'b0;
                end
                if (r_res_pend && i_slot_free) begin
                    o_res_valid = 1'b1;
                    n_res_pend  = 1'b0;
                end
                if (accept) begin
                    unique case (i_data.op)
                        OP_LOAD_KEY: begin
                            o_key_we = RC4_LEN_W'(i_data.key_index) < DEPTH_LEN;
                        end
                        OP_SCHEDULE: begin
                            n_a    = '0;
                            n_j    = '0;
                            n_kpos = '0;
                        end
                        OP_CRYPT: begin
                            if (r_scheduled) begin
                                n_i              = r_i + 8'd1;
                                n_val            = i_data.value;
                                o_sbox_req.re    = 1'b1;
                                o_sbox_req.raddr = r_i + 8'd1;
                            end
                        end
                        default: begin
                            // drop unused op
                        end
                    endcase
                end
            end
            ST_INIT: begin
                o_sbox_req.we    = 1'b1;
                o_sbox_req.waddr = r_a;
                o_sbox_req.wdata = r_a;
                n_a              = r_a + 8'd1;
            end
            ST_KSA0: begin
                if (r_wb_pend) begin
                    o_sbox_req.we    = 1'b1;
                    o_sbox_req.waddr = r_wb_addr;
                    o_sbox_req.wdata = r_wb_data;
                    n_wb_pend        = 1'b0;
                end
                o_sbox_req.re    = 1'b1;
                o_sbox_req.raddr = r_a;
                o_key_re         = 1'b1;
            end
            ST_KSA1: begin
                n_j              = r_j + i_sbox_rdata + i_key_rdata;
                n_sa             = i_sbox_rdata;
                o_sbox_req.re    = 1'b1;
                o_sbox_req.raddr = r_j + i_sbox_rdata + i_key_rdata;
            end
            ST_KSA2: begin
                o_sbox_req.we    = 1'b1;
                o_sbox_req.waddr = r_a;
                o_sbox_req.wdata = i_sbox_rdata;
                n_wb_pend        = 1'b1;
                n_wb_addr        = r_j;
                n_wb_data        = r_sa;
                n_a              = r_a + 8'd1;
                n_kpos           = (kpos_inc >= eff_len) ? '0 : kpos_inc[KW-1:0];
                if (r_a == LAST_IDX) begin
                    n_i         = '0;
                    n_j         = '0;
                    n_scheduled = 1'b1;
                    n_res_pend  = 1'b1;
                    n_res_sched = 1'b1;
                end
            end
            ST_DATA1: begin
                n_j              = r_j + i_sbox_rdata;
                n_sa             = i_sbox_rdata;
                o_sbox_req.re    = 1'b1;
                o_sbox_req.raddr = r_j + i_sbox_rdata;
            end
            ST_DATA2: begin
                // S[i] takes S[j] now; S[j] takes S[i] on the next free write slot
                o_sbox_req.we    = 1'b1;
                o_sbox_req.waddr = r_i;
                o_sbox_req.wdata = i_sbox_rdata;
                o_sbox_req.re    = 1'b1;
                o_sbox_req.raddr = r_sa + i_sbox_rdata;
                n_t              = r_sa + i_sbox_rdata;
                n_wb_pend        = 1'b1;
                n_wb_addr        = r_j;
                n_wb_data        = r_sa;
                n_res_pend       = 1'b1;
                n_res_sched      = 1'b0;
            end
            default: begin
                o_sbox_req = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_i         <= '0;
            r_j         <= '0;
            r_wb_pend   <= 1'b0;
            r_res_pend  <= 1'b0;
            r_scheduled <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_i         <= n_i;
            r_j         <= n_j;
            r_wb_pend   <= n_wb_pend;
            r_res_pend  <= n_res_pend;
            r_scheduled <= n_scheduled;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a         <= n_a;
        r_sa        <= n_sa;
        r_t         <= n_t;
        r_val       <= n_val;
        r_kpos      <= n_kpos;
        r_wb_addr   <= n_wb_addr;
        r_wb_data   <= n_wb_data;
        r_res_sched <= n_res_sched;
    end

`ifndef SYNTHESIS
    a_init_no_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_INIT) |-> !r_wb_pend)
        else $error("queued write-back left over at start of schedule");

    a_data_needs_sched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DATA1) |-> r_scheduled)
        else $error("data byte started without a schedule");

    a_data_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DATA2) |=> (r_state == ST_IDLE) && r_res_pend && !r_res_sched)
        else $error("data byte finished without a queued result");

    a_kpos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_KSA0) |-> (RC4_LEN_W'(r_kpos) < eff_len))
        else $error("key position beyond key length");
`endif

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import rc4_pkg::*;

    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam int         RESET_CYCLES = 7;
    localparam int         DRAIN_CYCLES = 32;
    localparam int         STALL_LIMIT  = 5000;
    localparam int         NUM_PHASES   = 8;
    localparam int         PHASE_ITEMS  = 120;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] key_index;
        logic [7:0] value;
        bit         typed;
        logic [7:0] out_byte;
        logic       schedule_done;
    } t_directed_row;

    // Data before any schedule and op 3 come first; expected bytes only for acks.
    localparam t_directed_row DIRECTED [20] = '{
        '{OP_CRYPT,    8'h00, 8'hFF, 1'b0, 8'h00, 1'b0},
        '{OP_UNUSED,   8'hFF, 8'hFF, 1'b0, 8'h00, 1'b0},
        '{OP_CRYPT,    8'h00, 8'h00, 1'b0, 8'h00, 1'b0},
        '{OP_LOAD_KEY, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0},
        '{OP_SCHEDULE, 8'h00, 8'h00, 1'b1, 8'h00, 1'b1},
        '{OP_CRYPT,    8'h00, 8'h00, 1'b0, 8'h00, 1'b0},
        '{OP_CRYPT,    8'hFF, 8'hFF, 1'b0, 8'h00, 1'b0},
        '{OP_CRYPT,    8'h00, 8'hA5, 1'b0, 8'h00, 1'b0},
        '{OP_LOAD_KEY, 8'hFF, 8'hFF, 1'b0, 8'h00, 1'b0},
        '{OP_LOAD_KEY, 8'h00, 8'hFF, 1'b0, 8'h00, 1'b0},
        '{OP_SCHEDULE, 8'hFF, 8'hFF, 1'b1, 8'h00, 1'b1},
        '{OP_CRYPT,    8'h00, 8'h00, 1'b0, 8'h00, 1'b0},
        '{OP_CRYPT,    8'h00, 8'hFF, 1'b0, 8'h00, 1'b0},
        '{OP_UNUSED,   8'h00, 8'h00, 1'b0, 8'h00, 1'b0},
        '{OP_CRYPT,    8'h00, 8'h5A, 1'b0, 8'h00, 1'b0},
        '{OP_SCHEDULE, 8'h00, 8'h00, 1'b1, 8'h00, 1'b1},
        '{OP_CRYPT,    8'h00, 8'h00, 1'b0, 8'h00, 1'b0},
        '{OP_LOAD_KEY, 8'h7F, 8'h80, 1'b0, 8'h00, 1'b0},
        '{OP_CRYPT,    8'h00, 8'h01, 1'b0, 8'h00, 1'b0},
        '{OP_CRYPT,    8'h00, 8'hFE, 1'b0, 8'h00, 1'b0}
    };

    localparam logic [8:0] KEY_LEN_PLAN [NUM_PHASES] = '{
        9'd1, 9'd256, 9'd0, 9'd511, 9'd5, 9'd16, 9'd255, 9'd2
    };

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_valid     = 1'b0;
    t_rc4_in              i_data      = '0;
    logic                 o_stall;
    logic                 o_valid;
    t_rc4_out             o_data;
    logic                 i_stall     = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [RC4_LEN_W-1:0] i_cfg_data  = '0;

    // Cipher state as the block should hold it
    logic [7:0]           perm_table [RC4_PERM_SIZE];
    logic [7:0]           key_bytes  [RC4_KEY_DEPTH];
    bit                   key_loaded [RC4_KEY_DEPTH];
    logic [7:0]           idx_i;
    logic [7:0]           idx_j;
    bit                   keyed;
    logic [RC4_LEN_W-1:0] key_len_reg;

    t_rc4_out awaited_outputs [$];

    int sender_idle_pct = 0;
    int stall_pct       = 0;
    int mismatch_count  = 0;
    int outputs_checked = 0;
    int idle_cycles     = 0;
    int n_loads         = 0;
    int n_schedules     = 0;
    int n_crypts        = 0;
    int n_dropped       = 0;

    rc4_stream_cipher u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_data      (i_data),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .o_data      (o_data),
        .i_stall     (i_stall),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 200) begin
            $display("MISMATCH @%0t: %s", $time, msg);
        end
        mismatch_count++;
    endtask

    function automatic int effective_length(input logic [RC4_LEN_W-1:0] raw);
        if (raw == 0) return 1;
        if (raw > RC4_KEY_DEPTH) return RC4_KEY_DEPTH;
        return int'(raw);
    endfunction

    function automatic t_rc4_in make_req(input logic [1:0] op, input logic [7:0] idx,
                                         input logic [7:0] val);
        t_rc4_in r;
        r.op        = op;
        r.key_index = idx;
        r.value     = val;
        return r;
    endfunction

    function automatic bit predict_cipher_output(input t_rc4_in req, output t_rc4_out res);
        int         len;
        int         kpos;
        logic [7:0] b;
        logic [7:0] tmp;
        logic [7:0] t;
        res = '0;
        case (req.op)
            OP_LOAD_KEY: begin
                key_bytes[req.key_index]  = req.value;
                key_loaded[req.key_index] = 1'b1;
                return 1'b0;
            end
            OP_SCHEDULE: begin
                len  = effective_length(key_len_reg);
                kpos = 0;
                b    = 8'd0;
                for (int a = 0; a < RC4_PERM_SIZE; a++) perm_table[a] = 8'(a);
                for (int a = 0; a < RC4_PERM_SIZE; a++) begin
                    b             = b + perm_table[a] + key_bytes[kpos];
                    tmp           = perm_table[a];
                    perm_table[a] = perm_table[b];
                    perm_table[b] = tmp;
                    kpos++;
                    if (kpos >= len) kpos = 0;
                end
                idx_i             = 8'd0;
                idx_j             = 8'd0;
                keyed             = 1'b1;
                res.schedule_done = 1'b1;
                return 1'b1;
            end
            OP_CRYPT: begin
                if (!keyed) return 1'b0;
                idx_i             = idx_i + 8'd1;
                idx_j             = idx_j + perm_table[idx_i];
                tmp               = perm_table[idx_i];
                perm_table[idx_i] = perm_table[idx_j];
                perm_table[idx_j] = tmp;
                t                 = perm_table[idx_i] + perm_table[idx_j];
                res.out_byte      = req.value ^ perm_table[t];
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(input t_rc4_in req, input bit use_typed = 1'b0,
                                input t_rc4_out typed_out = '0);
        t_rc4_out predicted;
        bit       has_out;
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= req;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        has_out = predict_cipher_output(req, predicted);
        if (has_out) begin
            awaited_outputs.insert(awaited_outputs.size(), use_typed ? typed_out : predicted);
        end
        if (req.op == OP_LOAD_KEY) n_loads++;
        else if (!has_out) n_dropped++;
        else if (req.op == OP_SCHEDULE) n_schedules++;
        else n_crypts++;
        @(negedge i_clk);
    endtask

    task automatic hold_until_drained();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (awaited_outputs.size() != 0);
    endtask

    task automatic settle();
        hold_until_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_key_length(input logic [RC4_LEN_W-1:0] raw);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= raw;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        key_len_reg = raw;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic run_directed();
        t_rc4_out typed;
        for (int r = 0; r < $size(DIRECTED); r++) begin
            typed.out_byte      = DIRECTED[r].out_byte;
            typed.schedule_done = DIRECTED[r].schedule_done;
            send_request(make_req(DIRECTED[r].op, DIRECTED[r].key_index, DIRECTED[r].value),
                         DIRECTED[r].typed, typed);
        end
    endtask

    // Messages: a few key loads, fill any key bytes the schedule would read
    // unwritten, usually a reschedule, then a burst of data with some op 3 noise.
    task automatic run_random_phase(input int budget);
        int sent;
        int len;
        int n;
        int idx;
        sent = 0;
        len  = effective_length(key_len_reg);
        while (sent < budget) begin
            n = $urandom_range(6);
            repeat (n) begin
                idx = ($urandom_range(7) == 0) ? $urandom_range(255) : $urandom_range(len - 1);
                send_request(make_req(OP_LOAD_KEY, 8'(idx), 8'($urandom_range(255))));
                sent++;
            end
            for (int k = 0; k < len; k++) begin
                if (!key_loaded[k]) begin
                    send_request(make_req(OP_LOAD_KEY, 8'(k), 8'($urandom_range(255))));
                    sent++;
                end
            end
            if ($urandom_range(9) == 0) hold_until_drained();
            if ($urandom_range(7) != 0) begin
                send_request(make_req(OP_SCHEDULE, 8'($urandom_range(255)),
                                      8'($urandom_range(255))));
                sent++;
            end
            n = $urandom_range(40, 1);
            repeat (n) begin
                if ($urandom_range(19) == 0) begin
                    send_request(make_req(OP_UNUSED, 8'($urandom_range(255)),
                                          8'($urandom_range(255))));
                end
                case ($urandom_range(9))
                    0:       idx = 0;
                    1:       idx = 255;
                    default: idx = $urandom_range(255);
                endcase
                send_request(make_req(OP_CRYPT, 8'($urandom_range(255)), 8'(idx)));
                sent++;
            end
        end
    endtask

    always @(posedge i_clk) begin : check_outputs
        t_rc4_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            outputs_checked++;
            if (awaited_outputs.size() == 0) begin
                report_mismatch($sformatf("unexpected output %h", o_data));
            end else begin
                want = awaited_outputs.pop_front();
                if (o_data.out_byte !== want.out_byte) begin
                    report_mismatch($sformatf("out_byte %h, expected %h",
                                              o_data.out_byte, want.out_byte));
                end
                if (o_data.schedule_done !== want.schedule_done) begin
                    report_mismatch($sformatf("schedule_done %b, expected %b",
                                              o_data.schedule_done, want.schedule_done));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
                $display("testbench failed");
                $finish;
            end
        end
    end

    initial begin
        for (int a = 0; a < RC4_PERM_SIZE; a++) perm_table[a] = 8'(a);
        for (int a = 0; a < RC4_KEY_DEPTH; a++) begin
            key_bytes[a]  = 8'd0;
            key_loaded[a] = 1'b0;
        end
        idx_i       = 8'd0;
        idx_j       = 8'd0;
        keyed       = 1'b0;
        key_len_reg = 9'd1;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        run_directed();
        hold_until_drained();

        for (int p = 0; p < NUM_PHASES; p++) begin
            settle();
            write_key_length((p == NUM_PHASES - 1) ? 9'($urandom_range(256, 2))
                                                   : KEY_LEN_PLAN[p]);
            case (p % 4)
                0:       begin sender_idle_pct = 0;  stall_pct = 0;  end
                1:       begin sender_idle_pct = 50; stall_pct = 0;  end
                2:       begin sender_idle_pct = 0;  stall_pct = 50; end
                default: begin sender_idle_pct = 32; stall_pct = 32; end
            endcase
            run_random_phase(PHASE_ITEMS);
        end
        settle();

        $display("covered %0d key loads, %0d schedules, %0d data bytes, %0d dropped requests",
                 n_loads, n_schedules, n_crypts, n_dropped);
        $display("over %0d key-length settings; %0d outputs compared, %0d mismatches",
                 NUM_PHASES + 1, outputs_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/rc4_pkg.sv
rtl/core/rc4_key_mem.sv
rtl/core/rc4_sbox_mem.sv
rtl/core/rc4_engine.sv
rtl/core/rc4_stream_cipher.sv
dv/testbench.sv
